FILE: sv/gds_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gds_pkg
// Shared types and constants for the grid derivative stencil.
// ---------------------------------------------------------------------------
package gds_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int DIFF_BITS   = SAMPLE_BITS + 4;   // four-term sums, negated
    localparam int COORD_BITS  = 10;
    localparam int RES_BITS    = 64;
    localparam int CFG_BITS    = 11;
    localparam int WIN_SIZE    = 9;

    localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_MUL,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic accept;   // take a sample, issue line store read
        logic load;     // write line stores, shift window, build point mask
        logic pick;     // select next point, form differences
        logic mul;      // scale differences into output register
    } cmd_t;

    typedef struct packed {
        logic pend;     // points left to emit
        logic sent;     // output request taken
    } sts_t;

endpackage

FILE: sv/grid_derivative_stencil_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grid_derivative_stencil_unit
// Central-difference derivative stencil over a raster grid of Q16.16 samples.
// ---------------------------------------------------------------------------
// Samples enter in raster order, one at a time. A sample that produces no
// result passes through accept, line store access and scan; each result it
// produces adds point select, scaling multiply and output, plus any wait on
// m_tready, for up to four results per sample. The sequencer steps through
// the pending points over one shared difference and multiply unit, so a new
// sample is taken only after the last one is through. Results lag one row
// and one column; row and frame ends flush the held-back points, with
// m_tlast on the final result of each sample. The user must write frame
// size through cfg_* only while the unit is idle; it is not enforced.
module grid_derivative_stencil_unit
    import gds_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [0:0]             cfg_index,
    input  logic [CFG_BITS-1:0]    cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [SAMPLE_BITS-1:0] s_tdata,   // sample
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // column, grid_row, second_xx, second_yy, second_mixed, first_x, first_y
    output logic [2*COORD_BITS+5*RES_BITS+3:0] m_tdata,
    output logic                   m_tlast
);

    cmd_t cmd;
    sts_t sts;

    gds_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gds_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: sv/gds_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gds_ctrl
// Sequencer: one sample at a time, then its pending points one by one.
// ---------------------------------------------------------------------------
module gds_ctrl
    import gds_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.load   = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (sts.pend) begin
                    cmd.pick   = 1'b1;
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (sts.sent) begin
                    state_next = ST_SCAN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

FILE: sv/gds_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gds_datapath
// Line stores, 3x3 window, difference and scaling units, output register.
// ---------------------------------------------------------------------------
module gds_datapath
    import gds_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [CFG_BITS-1:0]         cfg_wdata,
    input  logic [SAMPLE_BITS-1:0]      s_tdata,
    input  cmd_t                        cmd,
    output sts_t                        sts,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [2*COORD_BITS+5*RES_BITS+3:0] m_tdata,
    output logic                        m_tlast
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WD = $clog2(MAX_WIDTH + 1);
    localparam int HD = $clog2(MAX_HEIGHT + 1);

    localparam int PXX = DIFF_BITS + 2*WD + 1;
    localparam int PYY = DIFF_BITS + 2*HD + 1;
    localparam int PXY = DIFF_BITS + WD + HD + 1;
    localparam int PX  = DIFF_BITS + WD + 1;
    localparam int PY  = DIFF_BITS + HD + 1;

    logic [CFG_BITS-1:0] width_cfg_reg, height_cfg_reg;
    logic [WD-1:0]       w_eff;
    logic [HD-1:0]       h_eff;

    logic [SAMPLE_BITS-1:0] upper_mem  [MAX_WIDTH];
    logic [SAMPLE_BITS-1:0] middle_mem [MAX_WIDTH];
    logic [SAMPLE_BITS-1:0] top_rd_reg, mid_rd_reg;

    logic signed [SAMPLE_BITS-1:0] win_reg [WIN_SIZE];
    logic [SAMPLE_BITS-1:0] samp_reg;
    logic [CW-1:0]          col_count_reg, c_reg;
    logic [RW-1:0]          row_count_reg, r_reg;
    logic [3:0]             mask_reg;
    logic                   row_end, last_row;

    logic [2*WD-1:0]        kxx_reg;
    logic [2*HD-1:0]        kyy_reg;
    logic [WD+HD-1:0]       kxy_reg;

    logic [CW-1:0]          px_reg, px;
    logic [RW-1:0]          py_reg, py;
    logic                   last_reg;
    logic signed [DIFF_BITS-1:0] nxx_reg, nyy_reg, nxy_reg, nx_reg, ny_reg;

    logic [COORD_BITS-1:0]  col_out_reg, row_out_reg;
    logic [RES_BITS-1:0]    xx_out_reg, yy_out_reg, xy_out_reg, x_out_reg, y_out_reg;
    logic                   last_out_reg, out_valid_reg;

    // pick logic
    logic [1:0] idx, rr, cc, rp, rn, cp, cn;
    logic [3:0] mask_left;
    logic signed [DIFF_BITS-1:0] g_ctr, g_rcn, g_rcp, g_rnc, g_rpc;
    logic signed [DIFF_BITS-1:0] g_nn, g_pp, g_np, g_pn;

    function automatic logic signed [DIFF_BITS-1:0] win_at(
        input logic signed [SAMPLE_BITS-1:0] w [WIN_SIZE],
        input logic [1:0] row, input logic [1:0] col);
        logic [3:0] i;
        i = 4'(row) * 4'd3 + 4'(col);
        return DIFF_BITS'(w[i]);
    endfunction

    // effective frame size: zero acts as one, large values clamp
    always_comb begin
        if (width_cfg_reg == '0)                  w_eff = WD'(1);
        else if (int'(width_cfg_reg) > MAX_WIDTH) w_eff = WD'(MAX_WIDTH);
        else                                      w_eff = WD'(width_cfg_reg);
        if (height_cfg_reg == '0)                   h_eff = HD'(1);
        else if (int'(height_cfg_reg) > MAX_HEIGHT) h_eff = HD'(MAX_HEIGHT);
        else                                        h_eff = HD'(height_cfg_reg);
    end

    assign row_end  = int'(c_reg) >= int'(w_eff) - 1;
    assign last_row = int'(r_reg) >= int'(h_eff) - 1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= CFG_BITS'(1024);
            height_cfg_reg <= CFG_BITS'(1024);
        end else if (cfg_we) begin
            if (cfg_index == REG_FRAME_WIDTH)  width_cfg_reg  <= cfg_wdata;
            if (cfg_index == REG_FRAME_HEIGHT) height_cfg_reg <= cfg_wdata;
        end
    end

    // line stores: read on accept, write back on load
    always_ff @(posedge aclk) begin
        if (cmd.accept) top_rd_reg <= upper_mem[col_count_reg];
        if (cmd.load)   upper_mem[c_reg] <= mid_rd_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) mid_rd_reg <= middle_mem[col_count_reg];
        if (cmd.load)   middle_mem[c_reg] <= samp_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            samp_reg <= s_tdata;
            c_reg    <= col_count_reg;
            r_reg    <= row_count_reg;
        end
        if (cmd.load) begin
            kxx_reg <= (2*WD)'(w_eff) * (2*WD)'(w_eff);
            kyy_reg <= (2*HD)'(h_eff) * (2*HD)'(h_eff);
            kxy_reg <= (WD+HD)'(w_eff) * (WD+HD)'(h_eff);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            mask_reg      <= '0;
            for (int i = 0; i < WIN_SIZE; i++) win_reg[i] <= '0;
        end else if (cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i*3]   <= win_reg[i*3+1];
                win_reg[i*3+1] <= win_reg[i*3+2];
            end
            win_reg[2] <= top_rd_reg;
            win_reg[5] <= mid_rd_reg;
            win_reg[8] <= samp_reg;
            mask_reg <= {last_row && row_end, last_row && (c_reg != '0),
                         (r_reg != '0) && row_end, (r_reg != '0) && (c_reg != '0)};
            if (row_end) begin
                col_count_reg <= '0;
                row_count_reg <= last_row ? '0 : r_reg + RW'(1);
            end else begin
                col_count_reg <= c_reg + CW'(1);
            end
        end else if (cmd.pick) begin
            mask_reg <= mask_left;
        end
    end

    // lowest pending point; bit 0 is (c-1,r-1), bit 3 is (c,r)
    always_comb begin
        casez (mask_reg)
            4'b???1: idx = 2'd0;
            4'b??10: idx = 2'd1;
            4'b?100: idx = 2'd2;
            default: idx = 2'd3;
        endcase
        mask_left = mask_reg & ~(4'b0001 << idx);
        rr = idx[1] ? 2'd2 : 2'd1;
        cc = idx[0] ? 2'd2 : 2'd1;
        px = idx[0] ? c_reg : c_reg - CW'(1);
        py = idx[1] ? r_reg : r_reg - RW'(1);
        rp = (py == '0) ? rr : rr - 2'd1;
        rn = (int'(py) >= int'(h_eff) - 1 || rr == 2'd2) ? rr : rr + 2'd1;
        cp = (px == '0) ? cc : cc - 2'd1;
        cn = (int'(px) >= int'(w_eff) - 1 || cc == 2'd2) ? cc : cc + 2'd1;
        g_ctr = win_at(win_reg, rr, cc);
        g_rcn = win_at(win_reg, rr, cn);
        g_rcp = win_at(win_reg, rr, cp);
        g_rnc = win_at(win_reg, rn, cc);
        g_rpc = win_at(win_reg, rp, cc);
        g_nn  = win_at(win_reg, rn, cn);
        g_pp  = win_at(win_reg, rp, cp);
        g_np  = win_at(win_reg, rn, cp);
        g_pn  = win_at(win_reg, rp, cn);
    end

    always_ff @(posedge aclk) begin
        if (cmd.pick) begin
            px_reg   <= px;
            py_reg   <= py;
            last_reg <= (mask_left == '0);
            nxx_reg  <= (g_ctr <<< 1) - g_rcn - g_rcp;
            nyy_reg  <= (g_ctr <<< 1) - g_rnc - g_rpc;
            nxy_reg  <= g_np + g_pn - g_nn - g_pp;
            nx_reg   <= g_rcp - g_rcn;
            ny_reg   <= g_rpc - g_rnc;
        end
    end

    // scaling: floor(v * k / 4) or / 16, all fit in 64 bits
    logic signed [PXX-1:0] p_xx;
    logic signed [PYY-1:0] p_yy;
    logic signed [PXY-1:0] p_xy;
    logic signed [PX-1:0]  p_x;
    logic signed [PY-1:0]  p_y;

    assign p_xx = PXX'(nxx_reg) * PXX'($signed({1'b0, kxx_reg}));
    assign p_yy = PYY'(nyy_reg) * PYY'($signed({1'b0, kyy_reg}));
    assign p_xy = PXY'(nxy_reg) * PXY'($signed({1'b0, kxy_reg}));
    assign p_x  = PX'(nx_reg)   * PX'($signed({1'b0, w_eff}));
    assign p_y  = PY'(ny_reg)   * PY'($signed({1'b0, h_eff}));

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            col_out_reg  <= COORD_BITS'(px_reg);
            row_out_reg  <= COORD_BITS'(py_reg);
            xx_out_reg   <= RES_BITS'(p_xx >>> 2);
            yy_out_reg   <= RES_BITS'(p_yy >>> 2);
            xy_out_reg   <= RES_BITS'(p_xy >>> 4);
            x_out_reg    <= RES_BITS'(p_x >>> 2);
            y_out_reg    <= RES_BITS'(p_y >>> 2);
            last_out_reg <= last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.mul) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.pend = (mask_reg != '0);
    assign sts.sent = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = last_out_reg;
    assign m_tdata  = {4'b0, y_out_reg, x_out_reg, xy_out_reg, yy_out_reg, xx_out_reg,
                       row_out_reg, col_out_reg};

    a_col_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && row_end) |=> (col_count_reg == '0))
        else $error("column counter did not wrap at row end");

    a_pick_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.pick && mask_reg != '0) |=>
            ($countones(mask_reg) + 1 == $past($countones(mask_reg))))
        else $error("pick did not retire exactly one point");

    a_last_match: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (last_out_reg == (mask_reg == '0)))
        else $error("last flag disagrees with pending points");

endmodule
